FILE: hdl/pcs_pkg.sv
// Shared constants and types for the streaming Pearson correlation block.
package pcs_pkg;

  localparam int unsigned CORR_W    = 16;
  localparam int unsigned Q_W       = 16;
  localparam int unsigned ODD_W     = Q_W + 1;
  localparam int unsigned ODDSQ_W   = 2 * ODD_W;
  localparam int unsigned RHS_SHIFT = 32;

  localparam logic [Q_W-1:0] Q_ONE = 16'd32768;
  localparam logic [Q_W-1:0] Q_MAX = 16'd32767;

  typedef enum logic [3:0] {
    STEP_NSX2,
    STEP_SXSX,
    STEP_NSY2,
    STEP_SYSY,
    STEP_NSXY,
    STEP_SXSY,
    STEP_VXVY,
    STEP_NUMSQ,
    STEP_ODDSQ,
    STEP_LHS
  } step_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: hdl/pcs_fifo.sv
// Two-entry queue carrying accumulator snapshots from front to back.
module pcs_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DW-1:0]         wdata_i,
  input  logic                  pop_i,
  output logic [DW-1:0]         rdata_o,
  output pcs_pkg::fifo_status_t status_o
);
  import pcs_pkg::*;

  localparam int unsigned DEPTH = 2;

  logic [DW-1:0] mem_q [DEPTH];
  logic          wr_q;
  logic          rd_q;
  logic [1:0]    cnt_q;
  logic          do_push;
  logic          do_pop;

  assign status_o.full  = (cnt_q == 2'(DEPTH));
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wr_q == rd_q))
    else $error("empty queue with unequal pointers");

endmodule

FILE: hdl/pcs_front.sv
// Front end: accept bin pairs, accumulate the sums, hand a snapshot on the last pair.
module pcs_front #(
  parameter int unsigned COUNT_WIDTH = 20,
  parameter int unsigned MAX_BINS    = 4096,
  parameter int unsigned NW          = 13,
  parameter int unsigned SW          = 33,
  parameter int unsigned QW          = 53
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [COUNT_WIDTH-1:0]      x_count_i,
  input  logic [COUNT_WIDTH-1:0]      y_count_i,
  input  logic                        last_bin_i,
  input  pcs_pkg::fifo_status_t       fifo_status_i,
  output logic                        push_o,
  output logic [NW+2*SW+3*QW-1:0]     snap_o
);
  import pcs_pkg::*;

  localparam int unsigned PW = 2 * COUNT_WIDTH;

  logic [NW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [QW-1:0] sxx_q, sxx_d, syy_q, syy_d, sxy_q, sxy_d;
  logic [PW-1:0] xx, yy, xy;
  logic          accept;
  logic          room;

  assign in_stall_o = fifo_status_i.full;
  assign accept     = in_valid_i && !fifo_status_i.full;
  assign room       = (cnt_q < NW'(MAX_BINS));

  assign xx = PW'(x_count_i) * PW'(x_count_i);
  assign yy = PW'(y_count_i) * PW'(y_count_i);
  assign xy = PW'(x_count_i) * PW'(y_count_i);

  always_comb begin
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sxx_d = sxx_q;
    syy_d = syy_q;
    sxy_d = sxy_q;
    if (room) begin
      cnt_d = cnt_q + NW'(1);
      sx_d  = sx_q + SW'(x_count_i);
      sy_d  = sy_q + SW'(y_count_i);
      sxx_d = sxx_q + QW'(xx);
      syy_d = syy_q + QW'(yy);
      sxy_d = sxy_q + QW'(xy);
    end
  end

  assign push_o = accept && last_bin_i;
  assign snap_o = {cnt_d, sx_d, sy_d, sxx_d, syy_d, sxy_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
    end else if (accept) begin
      if (last_bin_i) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        sxx_q <= sxx_d;
        syy_q <= syy_d;
        sxy_q <= sxy_d;
      end
    end
  end

endmodule

FILE: hdl/pcs_mul.sv
// Shift-add multiplier retiring one multiplier bit per cycle.
module pcs_mul #(
  parameter int unsigned MW = 164,
  parameter int unsigned LW = 66
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] mcand_i,
  input  logic [LW-1:0] mplier_i,
  output logic          done_o,
  output logic [MW-1:0] product_o
);

  logic          run_q;
  logic [MW-1:0] mcand_q;
  logic [LW-1:0] mplier_q;
  logic [MW-1:0] acc_q;

  assign done_o    = run_q && (mplier_q == '0);
  assign product_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (done_o) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
    end else if (run_q && (mplier_q != '0)) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

endmodule

FILE: hdl/pcs_back.sv
// Back end: sequence variance, numerator and rounding search over the shared multiplier.
module pcs_back #(
  parameter int unsigned NW = 13,
  parameter int unsigned SW = 33,
  parameter int unsigned QW = 53,
  parameter int unsigned VW = 66,
  parameter int unsigned LW = 66,
  parameter int unsigned MW = 164
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcs_pkg::fifo_status_t             fifo_status_i,
  output logic                              pop_o,
  input  logic [NW+2*SW+3*QW-1:0]           snap_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pcs_pkg::CORR_W-1:0] correlation_o,
  output logic                              degenerate_o
);
  import pcs_pkg::*;

  state_e            state_q;
  step_e             step_q;
  logic [NW-1:0]     n_q;
  logic [SW-1:0]     sx_q, sy_q;
  logic [QW-1:0]     sxx_q, syy_q, sxy_q;
  logic [MW-1:0]     a_q, rhs_q;
  logic [VW-1:0]     vx_q, vy_q, num_q;
  logic [2*VW-1:0]   d_q;
  logic              neg_q;
  logic [Q_W-1:0]    lo_q, hi_q;
  logic [CORR_W-1:0] res_corr_q, out_corr_q;
  logic              res_deg_q, out_deg_q, out_valid_q;

  logic              mul_start, mul_done;
  logic [MW-1:0]     mul_mcand, mul_product;
  logic [LW-1:0]     mul_mplier;
  logic [MW-1:0]     diff;
  logic              ge;
  logic [VW-1:0]     vy_new;
  logic [Q_W:0]      mid_sum;
  logic [Q_W-1:0]    mid, lo_n, hi_n;
  logic [ODD_W-1:0]  odd;
  logic              slot_free;

  pcs_mul #(.MW(MW), .LW(LW)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .done_o   (mul_done),
    .product_o(mul_product)
  );

  assign pop_o     = (state_q == ST_IDLE) && !fifo_status_i.empty;
  assign mul_start = (state_q == ST_ISSUE);
  assign slot_free = !out_valid_q || !out_stall_i;

  assign ge      = (a_q >= mul_product);
  assign diff    = ge ? (a_q - mul_product) : (mul_product - a_q);
  assign vy_new  = ge ? VW'(diff) : '0;
  assign mid_sum = (Q_W+1)'(lo_q) + (Q_W+1)'(hi_q) + (Q_W+1)'(1);
  assign mid     = mid_sum[Q_W:1];
  assign odd     = {mid, 1'b0} - ODD_W'(1);
  assign lo_n    = (mul_product <= rhs_q) ? mid : lo_q;
  assign hi_n    = (mul_product <= rhs_q) ? hi_q : (mid - Q_W'(1));

  always_comb begin
    mul_mcand  = '0;
    mul_mplier = '0;
    unique case (step_q)
      STEP_NSX2:  begin mul_mcand = MW'(sxx_q); mul_mplier = LW'(n_q);  end
      STEP_SXSX:  begin mul_mcand = MW'(sx_q);  mul_mplier = LW'(sx_q); end
      STEP_NSY2:  begin mul_mcand = MW'(syy_q); mul_mplier = LW'(n_q);  end
      STEP_SYSY:  begin mul_mcand = MW'(sy_q);  mul_mplier = LW'(sy_q); end
      STEP_NSXY:  begin mul_mcand = MW'(sxy_q); mul_mplier = LW'(n_q);  end
      STEP_SXSY:  begin mul_mcand = MW'(sx_q);  mul_mplier = LW'(sy_q); end
      STEP_VXVY:  begin mul_mcand = MW'(vx_q);  mul_mplier = LW'(vy_q); end
      STEP_NUMSQ: begin mul_mcand = MW'(num_q); mul_mplier = LW'(num_q); end
      STEP_ODDSQ: begin mul_mcand = MW'(odd);   mul_mplier = LW'(odd);  end
      STEP_LHS:   begin mul_mcand = MW'(d_q);   mul_mplier = LW'(a_q[ODDSQ_W-1:0]); end
      default:    begin mul_mcand = '0;         mul_mplier = '0;        end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_NSX2;
      out_valid_q <= 1'b0;
      n_q   <= '0; sx_q  <= '0; sy_q  <= '0;
      sxx_q <= '0; syy_q <= '0; sxy_q <= '0;
      a_q   <= '0; rhs_q <= '0; vx_q  <= '0; vy_q <= '0;
      num_q <= '0; d_q   <= '0; neg_q <= 1'b0;
      lo_q  <= '0; hi_q  <= '0;
      res_corr_q <= '0; res_deg_q <= 1'b0;
      out_corr_q <= '0; out_deg_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!fifo_status_i.empty) begin
            {n_q, sx_q, sy_q, sxx_q, syy_q, sxy_q} <= snap_i;
            step_q  <= STEP_NSX2;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            state_q <= ST_ISSUE;
            case (step_q)
              STEP_NSX2: begin
                a_q    <= mul_product;
                step_q <= STEP_SXSX;
              end
              STEP_SXSX: begin
                vx_q   <= ge ? VW'(diff) : '0;
                step_q <= STEP_NSY2;
              end
              STEP_NSY2: begin
                a_q    <= mul_product;
                step_q <= STEP_SYSY;
              end
              STEP_SYSY: begin
                vy_q <= vy_new;
                if ((vx_q == '0) || (vy_new == '0)) begin
                  res_corr_q <= '0;
                  res_deg_q  <= 1'b1;
                  state_q    <= ST_EMIT;
                end else begin
                  step_q <= STEP_NSXY;
                end
              end
              STEP_NSXY: begin
                a_q    <= mul_product;
                step_q <= STEP_SXSY;
              end
              STEP_SXSY: begin
                neg_q  <= !ge;
                num_q  <= VW'(diff);
                step_q <= STEP_VXVY;
              end
              STEP_VXVY: begin
                d_q    <= (2*VW)'(mul_product);
                step_q <= STEP_NUMSQ;
              end
              STEP_NUMSQ: begin
                rhs_q  <= mul_product << RHS_SHIFT;
                lo_q   <= '0;
                hi_q   <= Q_ONE;
                step_q <= STEP_ODDSQ;
              end
              STEP_ODDSQ: begin
                a_q    <= mul_product;
                step_q <= STEP_LHS;
              end
              STEP_LHS: begin
                lo_q <= lo_n;
                hi_q <= hi_n;
                if (lo_n >= hi_n) begin
                  res_deg_q <= 1'b0;
                  if (neg_q) begin
                    res_corr_q <= CORR_W'(0) - CORR_W'(lo_n);
                  end else begin
                    res_corr_q <= (lo_n > Q_MAX) ? CORR_W'(Q_MAX) : CORR_W'(lo_n);
                  end
                  state_q <= ST_EMIT;
                end else begin
                  step_q <= STEP_ODDSQ;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_corr_q  <= res_corr_q;
            out_deg_q   <= res_deg_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign correlation_o = out_corr_q;
  assign degenerate_o  = out_deg_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_WAIT))
    else $error("multiplier finished outside the wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_deg_q) |-> (out_corr_q == '0))
    else $error("degenerate result with nonzero coefficient");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE && step_q == STEP_ODDSQ) |-> (lo_q < hi_q && hi_q <= Q_ONE))
    else $error("rounding search bounds out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_ISSUE && step_q == STEP_NSX2))
    else $error("snapshot taken without starting the sequence");

endmodule

FILE: hdl/pearson_correlation_stream.sv
// Top level: streaming Pearson correlation of two histograms in Q1.15.
//
//   channel  signals                                    direction
//   in       in_valid_i, in_stall_o, x_count_i,         bin pair into block
//            y_count_i, last_bin_i
//   out      out_valid_o, out_stall_i, correlation_o,   coefficient out of block
//            degenerate_o
//
// Bin pairs are taken one per cycle while the input is not stalled; the front accumulates up to MAX_BINS pairs.
// A last pair hands its sums to a two-entry queue; input stalls only while that is full.
// The back end runs its ten product kinds through the shared shift-add multiplier, which
// retires one multiplier bit per cycle; it takes the next snapshot from the queue only when idle.
// Reset clears all sums, the queue and the sequencer; no clearing pass is needed.
module pearson_correlation_stream #(
  parameter int unsigned MAX_BINS    = 4096,
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COUNT_WIDTH-1:0]            x_count_i,
  input  logic [COUNT_WIDTH-1:0]            y_count_i,
  input  logic                              last_bin_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pcs_pkg::CORR_W-1:0] correlation_o,
  output logic                              degenerate_o
);
  import pcs_pkg::*;

  localparam int unsigned NW = $clog2(MAX_BINS + 1);
  localparam int unsigned SW = COUNT_WIDTH + NW;
  localparam int unsigned QW = 2 * COUNT_WIDTH + NW;
  localparam int unsigned VW = 2 * COUNT_WIDTH + 2 * NW;
  localparam int unsigned LW = (VW > ODDSQ_W) ? VW : ODDSQ_W;
  localparam int unsigned MW = 2 * VW + RHS_SHIFT;
  localparam int unsigned DW = NW + 2 * SW + 3 * QW;

  fifo_status_t  fifo_status;
  logic          push;
  logic          pop;
  logic [DW-1:0] snap_w;
  logic [DW-1:0] snap_r;

  pcs_front #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .MAX_BINS   (MAX_BINS),
    .NW         (NW),
    .SW         (SW),
    .QW         (QW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_count_i    (x_count_i),
    .y_count_i    (y_count_i),
    .last_bin_i   (last_bin_i),
    .fifo_status_i(fifo_status),
    .push_o       (push),
    .snap_o       (snap_w)
  );

  pcs_fifo #(.DW(DW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (snap_w),
    .pop_i   (pop),
    .rdata_o (snap_r),
    .status_o(fifo_status)
  );

  pcs_back #(
    .NW(NW),
    .SW(SW),
    .QW(QW),
    .VW(VW),
    .LW(LW),
    .MW(MW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_status_i(fifo_status),
    .pop_o        (pop),
    .snap_i       (snap_r),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .correlation_o(correlation_o),
    .degenerate_o (degenerate_o)
  );

endmodule

FILE: sim/tb_pearson_correlation_stream.sv
// Testbench for the streaming Pearson correlation block: random histograms checked against a predictor.
`timescale 1ns / 100ps

module tb_pearson_correlation_stream;
  import pcs_pkg::*;

  localparam int unsigned MaxBins    = 256;
  localparam int unsigned CountWidth = 20;
  localparam int unsigned Wide       = 256;

  typedef struct packed {
    logic [CountWidth-1:0] x;
    logic [CountWidth-1:0] y;
    logic                  last;
  } bin_pair_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] corr;
    logic                     degen;
  } coeff_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CountWidth-1:0] x_count_i = '0;
  logic [CountWidth-1:0] y_count_i = '0;
  logic last_bin_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CORR_W-1:0] correlation_o;
  logic degenerate_o;

  bin_pair_t pending_pairs[$];
  coeff_t    expected_coeffs[$];
  int unsigned sent_pairs = 0;
  int unsigned error_count = 0;
  logic stimulus_loaded = 1'b0;
  logic pair_taken = 1'b0;
  logic hold_off = 1'b0;

  logic [12:0] acc_n = '0;
  logic [63:0] acc_sx = '0, acc_sy = '0, acc_sxx = '0, acc_syy = '0, acc_sxy = '0;

  pearson_correlation_stream #(
    .MAX_BINS   (MaxBins),
    .COUNT_WIDTH(CountWidth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_count_i    (x_count_i),
    .y_count_i    (y_count_i),
    .last_bin_i   (last_bin_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .correlation_o(correlation_o),
    .degenerate_o (degenerate_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic coeff_t correlate(logic [63:0] n, logic [63:0] sx, logic [63:0] sy,
                                       logic [63:0] sxx, logic [63:0] syy, logic [63:0] sxy);
    logic [Wide-1:0] a, b, vx, vy, num, d, rhs, odd, lhs;
    logic neg;
    int unsigned lo, hi, mid;
    coeff_t res;
    a  = Wide'(n) * Wide'(sxx);
    b  = Wide'(sx) * Wide'(sx);
    vx = (a >= b) ? a - b : '0;
    a  = Wide'(n) * Wide'(syy);
    b  = Wide'(sy) * Wide'(sy);
    vy = (a >= b) ? a - b : '0;
    if (vx == '0 || vy == '0) begin
      res.corr  = '0;
      res.degen = 1'b1;
      return res;
    end
    a   = Wide'(n) * Wide'(sxy);
    b   = Wide'(sx) * Wide'(sy);
    neg = a < b;
    num = neg ? b - a : a - b;
    d   = vx * vy;
    rhs = (num * num) << RHS_SHIFT;
    lo  = 0;
    hi  = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = Wide'(2 * mid - 1);
      lhs = odd * odd * d;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (neg) res.corr = CORR_W'(17'h10000 - 17'(lo));
    else res.corr = CORR_W'((lo > 32767) ? 32767 : lo);
    res.degen = 1'b0;
    return res;
  endfunction

  task automatic push_histogram(int unsigned len, int unsigned shape);
    bin_pair_t p;
    logic [CountWidth-1:0] base;
    base = CountWidth'($urandom);
    for (int unsigned k = 0; k < len; k++) begin
      case (shape)
        0: begin p.x = CountWidth'($urandom); p.y = CountWidth'($urandom); end
        1: begin
          p.x = CountWidth'($urandom_range(0, 15));
          p.y = CountWidth'($urandom_range(0, 15));
        end
        2: begin
          p.x = CountWidth'($urandom);
          p.y = p.x ^ CountWidth'($urandom_range(0, 255));
        end
        3: begin
          p.x = CountWidth'($urandom);
          p.y = ~p.x ^ CountWidth'($urandom_range(0, 255));
        end
        4: begin p.x = base; p.y = CountWidth'($urandom); end
        default: begin p.x = CountWidth'($urandom_range(0, 3) << 18); p.y = p.x; end
      endcase
      p.last = (k == len - 1);
      pending_pairs.push_back(p);
    end
  endtask

  task automatic push_pair(logic [CountWidth-1:0] x, logic [CountWidth-1:0] y, logic last);
    bin_pair_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  initial begin
    int unsigned total;
    // single pair, zero histogram, constant histogram
    push_pair(20'hFFFFF, 20'hFFFFF, 1'b1);
    push_pair('0, '0, 1'b0);
    push_pair('0, '0, 1'b1);
    push_histogram(4, 4);
    // perfect and inverse correlation at the field extremes
    push_pair('0, '0, 1'b0);
    push_pair(20'hFFFFF, 20'hFFFFF, 1'b1);
    push_pair('0, 20'hFFFFF, 1'b0);
    push_pair(20'hFFFFF, '0, 1'b0);
    push_pair('0, 20'hFFFFF, 1'b1);
    push_pair(20'h55555, 20'hAAAAA, 1'b0);
    push_pair(20'hAAAAA, 20'h55555, 1'b1);
    // overflowing histogram: pairs beyond the bin limit are dropped
    for (int unsigned k = 0; k < MaxBins + 3; k++)
      push_pair(20'hFFFFF - CountWidth'(k), CountWidth'(k * 3), k == MaxBins + 2);
    total = 0;
    while (total < 900) begin
      int unsigned len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 12);
      total += len;
      push_histogram(len, $urandom_range(0, 5));
    end
    stimulus_loaded = 1'b1;
  end

  // driver
  always @(negedge clk_i) begin
    int unsigned idle_pct;
    idle_pct = (sent_pairs < 400) ? 15 : (sent_pairs < 800) ? 58 : 0;
    if (rst_ni && (!in_valid_i || pair_taken)) begin
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        bin_pair_t p;
        p = pending_pairs.pop_front();
        in_valid_i <= 1'b1;
        x_count_i  <= p.x;
        y_count_i  <= p.y;
        last_bin_i <= p.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    int unsigned stall_pct;
    stall_pct = (sent_pairs < 400) ? 58 : (sent_pairs < 800) ? 15 : 0;
    out_stall_i <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    wait (sent_pairs >= 950);
    hold_off = 1'b1;
    repeat (6000) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // input monitor and predictor
  always @(posedge clk_i) begin
    pair_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      logic [63:0] n, sx, sy, sxx, syy, sxy;
      sent_pairs <= sent_pairs + 1;
      n = 64'(acc_n); sx = acc_sx; sy = acc_sy; sxx = acc_sxx; syy = acc_syy; sxy = acc_sxy;
      if (acc_n < MaxBins) begin
        n   = n + 64'd1;
        sx  = sx + 64'(x_count_i);
        sy  = sy + 64'(y_count_i);
        sxx = sxx + 64'(x_count_i) * 64'(x_count_i);
        syy = syy + 64'(y_count_i) * 64'(y_count_i);
        sxy = sxy + 64'(x_count_i) * 64'(y_count_i);
      end
      if (last_bin_i) begin
        expected_coeffs.push_back(correlate(n, sx, sy, sxx, syy, sxy));
        n = '0; sx = '0; sy = '0; sxx = '0; syy = '0; sxy = '0;
      end
      acc_n <= 13'(n); acc_sx <= sx; acc_sy <= sy;
      acc_sxx <= sxx; acc_syy <= syy; acc_sxy <= sxy;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      coeff_t want;
      if (expected_coeffs.size() == 0) begin
        $error("unexpected result transaction: correlation %0d degenerate %0b",
               correlation_o, degenerate_o);
        error_count++;
      end else begin
        want = expected_coeffs.pop_front();
        if (correlation_o !== want.corr) begin
          $error("correlation: expected %0d, actual %0d", want.corr, correlation_o);
          error_count++;
        end
        if (degenerate_o !== want.degen) begin
          $error("degenerate: expected %0b, actual %0b", want.degen, degenerate_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stimulus_loaded && pending_pairs.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || expected_coeffs.size() != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
    if (error_count == 0 && expected_coeffs.size() == 0) begin
      $display("pearson_correlation_stream verification clean");
    end else begin
      $display("pearson_correlation_stream verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("pearson_correlation_stream verification failed");
    $finish;
  end

endmodule

FILE: pearson_correlation_stream.f
hdl/pcs_pkg.sv
hdl/pcs_fifo.sv
hdl/pcs_front.sv
hdl/pcs_mul.sv
hdl/pcs_back.sv
hdl/pearson_correlation_stream.sv
sim/tb_pearson_correlation_stream.sv
